### rtl/core/sfod_pkg.sv
package sfod_pkg;

  localparam int MAG_W     = 16;
  localparam int VAL_W     = 26;
  localparam int FRAME_W   = 24;
  localparam int MULT_W    = 8;
  localparam int CFG_W     = 26;
  localparam int CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD_MULTIPLIER = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ONSET_LEVEL          = 1'd1;

  localparam logic [MULT_W-1:0] MULT_RESET  = 8'd24;
  localparam logic [VAL_W-1:0]  ONSET_RESET = 26'd655;

  typedef struct packed {
    logic [MAG_W-1:0] bin_magnitude;
    logic             frame_end;
    logic             track_end;
  } in_item_t;

  typedef struct packed {
    logic [FRAME_W-1:0] frame_number;
    logic [VAL_W-1:0]   peak_value;
    logic               is_onset;
    logic               last_result;
  } out_item_t;

  typedef struct packed {
    logic clear_run;
    logic track_clear;
    logic accept_en;
    logic step_rd;
    logic step_sum;
    logic step_mul;
    logic div_start;
    logic prune;
    logic emit;
    logic drain_start;
    logic d_dec;
    logic frame_done;
  } sfod_cmd_t;

  typedef struct packed {
    logic frame_accept;
    logic clear_last;
    logic adv_en;
    logic te;
    logic drain;
    logic d_zero;
    logic div_busy;
    logic emit_ok;
  } sfod_status_t;

endpackage

### rtl/core/sfod_divider.sv
module sfod_divider import sfod_pkg::*; #(
  parameter int DVD_W = 35,
  parameter int DVS_W = 5
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DVD_W-1:0] dividend,
  input  logic [DVS_W-1:0] divisor,
  output logic             busy,
  output logic [DVD_W-1:0] quotient
);

  localparam int CW = $clog2(DVD_W + 1);

  logic             busy_r;
  logic [CW-1:0]    cnt_r;
  logic [DVD_W-1:0] quo_r;
  logic [DVS_W-1:0] rem_r;
  logic [DVS_W-1:0] dvs_r;
  logic [DVS_W:0]   trial;
  logic [DVS_W:0]   trial_diff;
  logic             ge;
  logic [DVS_W-1:0] rem_nxt;

  always_comb begin
    trial      = {rem_r, quo_r[DVD_W-1]};
    ge         = trial >= {1'b0, dvs_r};
    trial_diff = trial - {1'b0, dvs_r};
    rem_nxt    = ge ? trial_diff[DVS_W-1:0] : trial[DVS_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= CW'(DVD_W);
    end else if (busy_r) begin
      cnt_r <= cnt_r - 1'b1;
      if (cnt_r == CW'(1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (busy_r) begin
      quo_r <= {quo_r[DVD_W-2:0], ge};
      rem_r <= rem_nxt;
    end
  end

  assign busy     = busy_r;
  assign quotient = quo_r;

endmodule

### rtl/core/sfod_datapath.sv
module sfod_datapath import sfod_pkg::*; #(
  parameter int BINS        = 1024,
  parameter int WINDOW_HALF = 10,
  parameter int MAG_BITS    = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  sfod_cmd_t            cmd,
  output sfod_status_t         status,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  in_item_t             in_item,
  output logic                 out_valid,
  input  logic                 out_stall,
  output out_item_t            out_item,
  input  logic                 cfg_write_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  localparam int SW         = (MAG_BITS < MAG_W) ? MAG_BITS : MAG_W;
  localparam int BW         = $clog2(BINS);
  localparam int RW         = $clog2(2 * WINDOW_HALF + 2);
  localparam int RING_DEPTH = 1 << RW;
  localparam int FW         = $clog2(2 * WINDOW_HALF + 2);
  localparam int DW         = $clog2(WINDOW_HALF + 1);
  localparam int WSW        = VAL_W + $clog2(2 * WINDOW_HALF + 1);
  localparam int PW         = WSW + MULT_W;
  localparam int DVD_W      = PW - 4;

  logic                accept;
  logic [SW-1:0]       mag;

  logic [SW-1:0]       prev_mem [BINS];
  logic [SW-1:0]       prev_rd_r;
  logic [VAL_W-1:0]    ring_mem [RING_DEPTH];
  logic [VAL_W-1:0]    ring_rd_r;

  logic                s1_valid_r;
  logic                s1_fe_r;
  logic [SW-1:0]       s1_mag_r;
  logic [SW-1:0]       diff;
  logic [VAL_W:0]      acc_sum;
  logic [VAL_W-1:0]    acc_nxt;
  logic [VAL_W-1:0]    acc_r;

  logic [BW-1:0]       bin_idx_r;
  logic [BW-1:0]       clr_cnt_r;
  logic                clear_last;

  logic                te_r;
  logic                drain_r;
  logic [DW-1:0]       d_r;
  logic [DW-1:0]       d_init;
  logic [FRAME_W-1:0]  frame_counter_r;
  logic [FW-1:0]       fill_count_r;
  logic [WSW-1:0]      window_sum_r;
  logic [WSW-1:0]      window_sum_nxt;

  logic [FW-1:0]       off;
  logic [FRAME_W-1:0]  centre;
  logic [RW-1:0]       k_addr;
  logic [RW-1:0]       c_addr;
  logic [RW-1:0]       sub_addr;
  logic                sub_en;
  logic                adv_en;
  logic [FW-1:0]       count;

  logic [PW-1:0]       prod_nxt;
  logic [PW-1:0]       prod_r;
  logic [VAL_W-1:0]    f_r;
  logic                div_busy;
  logic [DVD_W-1:0]    thr;
  logic [VAL_W-1:0]    cur_nxt;
  logic [VAL_W-1:0]    cur_r;
  logic [VAL_W-1:0]    held_r;
  logic                held_valid_r;
  logic [VAL_W-1:0]    peak;

  logic [MULT_W-1:0]   mult_r;
  logic [VAL_W-1:0]    onset_level_r;
  logic                out_valid_r;
  out_item_t           out_r;

  assign accept   = in_valid && cmd.accept_en;
  assign in_stall = !cmd.accept_en;
  assign mag      = in_item.bin_magnitude[SW-1:0];

  always_comb begin
    diff    = (s1_mag_r > prev_rd_r) ? s1_mag_r - prev_rd_r : '0;
    acc_sum = {1'b0, acc_r} + (VAL_W + 1)'(diff);
    acc_nxt = acc_sum[VAL_W] ? {VAL_W{1'b1}} : acc_sum[VAL_W-1:0];
  end

  assign clear_last = clr_cnt_r == BW'(BINS - 1);

  always_comb begin
    off      = drain_r ? FW'(d_r) : FW'(WINDOW_HALF);
    centre   = frame_counter_r - FRAME_W'(off);
    k_addr   = frame_counter_r[RW-1:0];
    c_addr   = centre[RW-1:0];
    sub_addr = c_addr - RW'(WINDOW_HALF + 1);
    sub_en   = {1'b0, fill_count_r} >= ((FW + 1)'(WINDOW_HALF + 1) + (FW + 1)'(off));
    adv_en   = drain_r || (fill_count_r >= FW'(WINDOW_HALF));
    if ({1'b0, fill_count_r} >= ((FW + 1)'(WINDOW_HALF) + (FW + 1)'(off))) begin
      count = off + FW'(WINDOW_HALF + 1);
    end else begin
      count = fill_count_r + 1'b1;
    end
    d_init = (fill_count_r >= FW'(WINDOW_HALF)) ? DW'(WINDOW_HALF - 1) : DW'(fill_count_r);
  end

  always_comb begin
    window_sum_nxt = window_sum_r - (sub_en ? WSW'(ring_rd_r) : '0)
                     + (drain_r ? '0 : WSW'(acc_r));
    prod_nxt       = PW'(window_sum_r) * PW'(mult_r);
    cur_nxt        = (thr <= DVD_W'(f_r)) ? f_r - thr[VAL_W-1:0] : '0;
    peak           = (held_r > cur_r) ? held_r : '0;
  end

  sfod_divider #(
    .DVD_W(DVD_W),
    .DVS_W(FW)
  ) u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (cmd.div_start),
    .dividend(prod_r[PW-1:4]),
    .divisor (count),
    .busy    (div_busy),
    .quotient(thr)
  );

  always_ff @(posedge clk) begin
    if (cmd.clear_run) begin
      prev_mem[clr_cnt_r] <= '0;
    end else if (accept) begin
      prev_mem[bin_idx_r] <= mag;
    end
    if (accept) begin
      prev_rd_r <= prev_mem[bin_idx_r];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.step_rd && !drain_r) begin
      ring_mem[k_addr] <= acc_r;
    end
    ring_rd_r <= ring_mem[cmd.step_rd ? sub_addr : c_addr];
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_fe_r  <= in_item.frame_end;
      s1_mag_r <= mag;
    end
    if (cmd.step_mul) begin
      prod_r <= prod_nxt;
      f_r    <= ring_rd_r;
    end
    if (cmd.prune) begin
      cur_r <= cur_nxt;
    end
    if (cmd.emit && held_valid_r) begin
      out_r.frame_number <= centre - 1'b1;
      out_r.peak_value   <= peak;
      out_r.is_onset     <= peak > onset_level_r;
      out_r.last_result  <= !te_r || (drain_r && (d_r == '0));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r      <= 1'b0;
      acc_r           <= '0;
      bin_idx_r       <= '0;
      clr_cnt_r       <= '0;
      te_r            <= 1'b0;
      drain_r         <= 1'b0;
      d_r             <= '0;
      frame_counter_r <= '0;
      fill_count_r    <= '0;
      window_sum_r    <= '0;
      held_r          <= '0;
      held_valid_r    <= 1'b0;
      out_valid_r     <= 1'b0;
      mult_r          <= MULT_RESET;
      onset_level_r   <= ONSET_RESET;
    end else begin
      s1_valid_r <= accept;

      if (cmd.clear_run) begin
        clr_cnt_r <= clear_last ? '0 : clr_cnt_r + 1'b1;
      end

      if (cmd.track_clear) begin
        acc_r           <= '0;
        bin_idx_r       <= '0;
        te_r            <= 1'b0;
        drain_r         <= 1'b0;
        d_r             <= '0;
        frame_counter_r <= '0;
        fill_count_r    <= '0;
        window_sum_r    <= '0;
        held_r          <= '0;
        held_valid_r    <= 1'b0;
      end else begin
        if (cmd.frame_done) begin
          acc_r           <= '0;
          frame_counter_r <= frame_counter_r + 1'b1;
          if (fill_count_r < FW'(2 * WINDOW_HALF + 1)) begin
            fill_count_r <= fill_count_r + 1'b1;
          end
        end else if (s1_valid_r && !s1_fe_r) begin
          acc_r <= acc_nxt;
        end

        if (accept) begin
          if (in_item.frame_end || (bin_idx_r == BW'(BINS - 1))) begin
            bin_idx_r <= '0;
          end else begin
            bin_idx_r <= bin_idx_r + 1'b1;
          end
          if (in_item.frame_end) begin
            te_r    <= in_item.track_end;
            drain_r <= 1'b0;
          end
        end

        if (cmd.drain_start) begin
          drain_r <= 1'b1;
          d_r     <= d_init;
        end else if (cmd.d_dec) begin
          d_r <= d_r - 1'b1;
        end

        if (cmd.step_sum) begin
          window_sum_r <= window_sum_nxt;
        end

        if (cmd.emit) begin
          held_r       <= cur_r;
          held_valid_r <= 1'b1;
        end
      end

      if (cmd.emit && held_valid_r) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end

      if (cfg_write_en) begin
        unique case (cfg_index)
          CFG_THRESHOLD_MULTIPLIER: mult_r        <= cfg_data[MULT_W-1:0];
          CFG_ONSET_LEVEL:          onset_level_r <= cfg_data[VAL_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_comb begin
    status.frame_accept = accept && in_item.frame_end;
    status.clear_last   = clear_last;
    status.adv_en       = adv_en;
    status.te           = te_r;
    status.drain        = drain_r;
    status.d_zero       = d_r == '0;
    status.div_busy     = div_busy;
    status.emit_ok      = !held_valid_r || !out_valid_r || !out_stall;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

endmodule

### rtl/core/sfod_ctrl.sv
module sfod_ctrl import sfod_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  sfod_status_t status,
  output sfod_cmd_t    cmd
);

  typedef enum logic [8:0] {
    S_CLEAR  = 9'b000000001,
    S_BIN    = 9'b000000010,
    S_RD     = 9'b000000100,
    S_SUM    = 9'b000001000,
    S_MUL    = 9'b000010000,
    S_DSTART = 9'b000100000,
    S_DIV    = 9'b001000000,
    S_PRUNE  = 9'b010000000,
    S_EMIT   = 9'b100000000
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   step_end;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    step_end  = 1'b0;
    unique case (state_r)
      S_CLEAR: begin
        cmd.clear_run = 1'b1;
        if (status.clear_last) begin
          state_nxt = S_BIN;
        end
      end
      S_BIN: begin
        cmd.accept_en = 1'b1;
        if (status.frame_accept) begin
          state_nxt = S_RD;
        end
      end
      S_RD: begin
        cmd.step_rd = 1'b1;
        state_nxt   = S_SUM;
      end
      S_SUM: begin
        cmd.step_sum = 1'b1;
        if (status.adv_en) begin
          state_nxt = S_MUL;
        end else begin
          step_end = 1'b1;
        end
      end
      S_MUL: begin
        cmd.step_mul = 1'b1;
        state_nxt    = S_DSTART;
      end
      S_DSTART: begin
        cmd.div_start = 1'b1;
        state_nxt     = S_DIV;
      end
      S_DIV: begin
        if (!status.div_busy) begin
          state_nxt = S_PRUNE;
        end
      end
      S_PRUNE: begin
        cmd.prune = 1'b1;
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (status.emit_ok) begin
          cmd.emit = 1'b1;
          step_end = 1'b1;
        end
      end
      default: begin
        state_nxt = S_CLEAR;
      end
    endcase

    if (step_end) begin
      if (!status.drain) begin
        if (status.te) begin
          cmd.drain_start = 1'b1;
          state_nxt       = S_RD;
        end else begin
          cmd.frame_done = 1'b1;
          state_nxt      = S_BIN;
        end
      end else if (status.d_zero) begin
        cmd.track_clear = 1'b1;
        state_nxt       = S_CLEAR;
      end else begin
        cmd.d_dec = 1'b1;
        state_nxt = S_RD;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

### rtl/core/spectral_flux_onset_detector_core.sv
// Channel   Direction  Handshake           Payload
// in_       input      in_valid/in_stall   in_item_t: one spectrum bin
// out_      output     out_valid/out_stall out_item_t: one reported frame
// cfg_      input      cfg_write_en        cfg_index, cfg_data
//
// Bins are taken one per cycle. After a frame end the input stalls while the window sum is
// updated and the threshold is computed, most of the stall in the bit-serial threshold
// divider; until WINDOW_HALF frames have passed only the window sum is updated. A track
// end adds up to WINDOW_HALF more such steps, then a clearing pass over all BINS entries
// of the previous-spectrum memory, as after reset.
// A result held by out_stall stalls the block only when the next frame must be reported.
module spectral_flux_onset_detector_core import sfod_pkg::*; #(
  parameter int BINS        = 1024,
  parameter int WINDOW_HALF = 10,
  parameter int MAG_BITS    = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  in_item_t             in_item,
  output logic                 out_valid,
  input  logic                 out_stall,
  output out_item_t            out_item,
  input  logic                 cfg_write_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  sfod_cmd_t    cmd;
  sfod_status_t status;

  sfod_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .status(status),
    .cmd   (cmd)
  );

  sfod_datapath #(
    .BINS       (BINS),
    .WINDOW_HALF(WINDOW_HALF),
    .MAG_BITS   (MAG_BITS)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .status      (status),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_item     (in_item),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_item    (out_item),
    .cfg_write_en(cfg_write_en),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

endmodule

### bench/tb_spectral_flux_onset_detector_core.sv
`timescale 1ns / 1ps

class onset_scoreboard #(int NBINS = 1024, int HALF = 10);
  localparam longint unsigned VAL_MAX = 64'h3FFFFFF;

  bit [15:0]            last_spectrum [NBINS];
  longint unsigned      flux_ring [64];
  longint unsigned      flux_sum;
  longint unsigned      window_total;
  longint unsigned      held_flux;
  longint unsigned      gain;
  longint unsigned      onset_min;
  int                   bin_pos;
  int                   frame_idx;
  int                   frames_seen;
  bit                   held_ok;
  int                   mismatches;
  sfod_pkg::out_item_t  frame_batch [$];
  sfod_pkg::out_item_t  expected_peaks [$];

  function new();
    gain = sfod_pkg::MULT_RESET;
    onset_min = sfod_pkg::ONSET_RESET;
    mismatches = 0;
    clear_track();
  endfunction

  function void clear_track();
    foreach (last_spectrum[i]) last_spectrum[i] = '0;
    foreach (flux_ring[i]) flux_ring[i] = 0;
    flux_sum = 0;
    window_total = 0;
    held_flux = 0;
    held_ok = 1'b0;
    bin_pos = 0;
    frame_idx = 0;
    frames_seen = 0;
  endfunction

  function void set_reg(logic [sfod_pkg::CFG_IDX_W-1:0] idx, logic [sfod_pkg::CFG_W-1:0] val);
    if (idx == sfod_pkg::CFG_THRESHOLD_MULTIPLIER) begin
      gain = val[sfod_pkg::MULT_W-1:0];
    end else begin
      onset_min = val[sfod_pkg::VAL_W-1:0];
    end
  endfunction

  function longint unsigned pruned_flux(int centre, longint unsigned count);
    longint unsigned thr;
    longint unsigned f;
    thr = (window_total * gain) / (16 * count);
    f = flux_ring[centre & 63];
    return (thr <= f) ? f - thr : 0;
  endfunction

  // The held frame is reported against the pruned value of the frame after it.
  function void hold_frame(int centre, longint unsigned cur);
    sfod_pkg::out_item_t r;
    longint unsigned v;
    if (held_ok) begin
      v = (held_flux > cur) ? held_flux : 0;
      r.frame_number = 24'(centre - 1);
      r.peak_value = 26'(v);
      r.is_onset = (v > onset_min);
      r.last_result = 1'b0;
      frame_batch.insert(frame_batch.size(), r);
    end
    held_flux = cur;
    held_ok = 1'b1;
  endfunction

  function void take_bin(sfod_pkg::in_item_t it);
    int idx;
    int mag;
    int prev_mag;
    int k;
    int prior;
    int span;
    int c;
    int d;
    longint unsigned cnt;
    frame_batch.delete();
    mag = it.bin_magnitude;
    idx = (bin_pos < NBINS) ? bin_pos : 0;
    prev_mag = last_spectrum[idx];
    last_spectrum[idx] = it.bin_magnitude;
    if (!it.frame_end) begin
      if (mag > prev_mag) begin
        flux_sum += longint'(mag - prev_mag);
        if (flux_sum > VAL_MAX) flux_sum = VAL_MAX;
      end
      bin_pos = (idx + 1 == NBINS) ? 0 : idx + 1;
      return;
    end
    k = frame_idx;
    prior = frames_seen;
    flux_ring[k & 63] = flux_sum;
    if (prior >= 2 * HALF + 1) window_total -= flux_ring[(k - 2 * HALF - 1) & 63];
    window_total += flux_sum;
    if (prior >= HALF) begin
      span = (prior < 2 * HALF) ? prior : 2 * HALF;
      c = k - HALF;
      hold_frame(c, pruned_flux(c, span + 1));
    end
    if (frames_seen < 2 * HALF + 1) frames_seen++;
    flux_sum = 0;
    bin_pos = 0;
    frame_idx = (k + 1) & 24'hFFFFFF;
    if (it.track_end) begin
      // Drain every frame still waiting on its successor, window clamped to the last frame.
      for (d = (prior >= HALF) ? HALF - 1 : prior; d >= 0; d--) begin
        c = k - d;
        if (prior >= HALF + 1 + d) window_total -= flux_ring[(c - HALF - 1) & 63];
        cnt = (prior >= d + HALF) ? d + HALF + 1 : prior + 1;
        hold_frame(c, pruned_flux(c, cnt));
      end
      clear_track();
    end
    if (frame_batch.size() > 0) frame_batch[$].last_result = 1'b1;
    expected_peaks = {expected_peaks, frame_batch};
  endfunction

  function void log_mismatch(string what, sfod_pkg::out_item_t want, sfod_pkg::out_item_t got);
    mismatches++;
    if (mismatches <= 10) begin
      $write("%0t: %s: expected frame %0d peak %0d onset %0d last %0d", $time, what,
             want.frame_number, want.peak_value, want.is_onset, want.last_result);
      $display(", got frame %0d peak %0d onset %0d last %0d",
               got.frame_number, got.peak_value, got.is_onset, got.last_result);
    end
  endfunction

  function void check_peak(sfod_pkg::out_item_t got);
    sfod_pkg::out_item_t want;
    if (expected_peaks.size() == 0) begin
      log_mismatch("unexpected transfer", '0, got);
      return;
    end
    want = expected_peaks.pop_front();
    if (got.frame_number !== want.frame_number || got.peak_value !== want.peak_value ||
        got.is_onset !== want.is_onset || got.last_result !== want.last_result) begin
      log_mismatch("wrong result", want, got);
    end
  endfunction
endclass

module tb_spectral_flux_onset_detector_core;
  import sfod_pkg::*;

  localparam int BINS          = 1024;
  localparam int WINDOW_HALF   = 10;
  localparam int LIMIT         = 1000000;
  localparam int SETTLE_CYCLES = 2000;
  localparam int HOLD_CYCLES   = 800;

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_stall;
  in_item_t             in_item;
  logic                 out_valid;
  logic                 out_stall;
  out_item_t            out_item;
  logic                 cfg_write_en;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;

  onset_scoreboard #(BINS, WINDOW_HALF) peaks;
  int cycle_count = 0;
  int stall_left = 0;
  int bins_sent = 0;
  bit quiet = 1'b0;
  bit hold_req = 1'b0;
  bit hold_taken = 1'b0;

  spectral_flux_onset_detector_core #(
    .BINS(BINS),
    .WINDOW_HALF(WINDOW_HALF),
    .MAG_BITS(16)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_item(in_item),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_item(out_item),
    .cfg_write_en(cfg_write_en),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT) begin
      $display("tb_spectral_flux_onset_detector_core failed");
      $finish;
    end
  end

  function automatic int gap_cycles();
    int r;
    r = $urandom_range(0, 99);
    if (r < 75) return 0;
    if (r < 96) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) peaks.check_peak(out_item);
    if (stall_left == 0 && hold_req && !hold_taken) begin
      hold_taken = 1'b1;
      stall_left = HOLD_CYCLES;
    end else if (stall_left == 0 && !quiet) begin
      stall_left = gap_cycles();
    end
    if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else begin
      out_stall <= 1'b0;
    end
  end

  task automatic send_bin(input logic [15:0] mag, input logic fe, input logic te);
    int gap;
    gap = quiet ? 0 : gap_cycles();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item <= '{bin_magnitude: mag, frame_end: fe, track_end: te};
    @(posedge clk);
    while (in_stall) @(posedge clk);
    peaks.take_bin('{bin_magnitude: mag, frame_end: fe, track_end: te});
    bins_sent++;
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (peaks.expected_peaks.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    @(posedge clk);
    cfg_write_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_write_en <= 1'b0;
    peaks.set_reg(idx, val);
  endtask

  function automatic logic [15:0] pick_mag(int mode);
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) return 16'h0000;
    if (r == 1) return 16'hFFFF;
    case (mode)
      0: return 16'($urandom_range(0, 65535));
      1: return 16'($urandom_range(0, 255));
      default: return 16'($urandom_range(61440, 65535));
    endcase
  endfunction

  task automatic random_track(input bit long_track);
    int r;
    int frames;
    int nb;
    int mode;
    r = $urandom_range(0, 99);
    if (long_track) frames = $urandom_range(25, 40);
    else if (r < 15) frames = $urandom_range(1, 10);
    else if (r < 75) frames = $urandom_range(11, 30);
    else frames = $urandom_range(31, 40);
    mode = $urandom_range(0, 2);
    for (int f = 0; f < frames; f++) begin
      nb = $urandom_range(1, 4);
      for (int b = 0; b < nb; b++) begin
        if (b == nb - 1) send_bin(pick_mag(mode), 1'b1, f == frames - 1);
        else send_bin(pick_mag(mode), 1'b0, $urandom_range(0, 19) == 0);
      end
    end
  endtask

  initial begin
    int phase;
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_item <= '0;
    cfg_write_en <= 1'b0;
    cfg_index <= CFG_THRESHOLD_MULTIPLIER;
    cfg_data <= '0;
    peaks = new();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    send_bin(16'hFFFF, 1'b0, 1'b0);
    send_bin(16'h0000, 1'b0, 1'b1);
    send_bin(16'hAAAA, 1'b0, 1'b0);
    send_bin(16'h5555, 1'b1, 1'b0);
    send_bin(16'h0000, 1'b1, 1'b1);
    send_bin(16'h1234, 1'b1, 1'b1);
    send_bin(16'hFFFF, 1'b0, 1'b0);
    send_bin(16'h0000, 1'b1, 1'b0);
    send_bin(16'hFFFF, 1'b0, 1'b0);
    send_bin(16'hFFFF, 1'b1, 1'b0);
    send_bin(16'h8000, 1'b1, 1'b0);
    send_bin(16'h7FFF, 1'b0, 1'b0);
    send_bin(16'h0001, 1'b1, 1'b1);
    send_bin(16'hFFFF, 1'b0, 1'b0);
    send_bin(16'h0000, 1'b1, 1'b0);
    send_bin(16'h00FF, 1'b0, 1'b0);
    send_bin(16'h0000, 1'b1, 1'b1);
    settle();

    phase = 0;
    while (bins_sent < 170) begin
      case (phase)
        0: begin
          write_reg(CFG_THRESHOLD_MULTIPLIER, '0);
          write_reg(CFG_ONSET_LEVEL, '0);
        end
        1: begin
          write_reg(CFG_THRESHOLD_MULTIPLIER, 26'hFF);
          write_reg(CFG_ONSET_LEVEL, 26'h3FFFFFF);
        end
        2: begin
          write_reg(CFG_THRESHOLD_MULTIPLIER, 26'd16);
          write_reg(CFG_ONSET_LEVEL, 26'($urandom_range(0, 5000)));
        end
        3: begin
          write_reg(CFG_THRESHOLD_MULTIPLIER, 26'(MULT_RESET));
          write_reg(CFG_ONSET_LEVEL, 26'(ONSET_RESET));
        end
        default: begin
          write_reg(CFG_THRESHOLD_MULTIPLIER, 26'($urandom_range(0, 255)));
          write_reg(CFG_ONSET_LEVEL, 26'($urandom_range(0, 200000)));
        end
      endcase
      quiet = (phase == 1);
      if (phase == 0) hold_req = 1'b1;
      random_track(phase == 0);
      settle();
      phase++;
    end
    quiet = 1'b0;

    if (peaks.mismatches == 0 && peaks.expected_peaks.size() == 0) begin
      $display("tb_spectral_flux_onset_detector_core passed");
    end else begin
      if (peaks.expected_peaks.size() != 0) begin
        $display("%0d expected results never arrived", peaks.expected_peaks.size());
      end
      $display("tb_spectral_flux_onset_detector_core failed");
    end
    $finish;
  end

endmodule

### spectral_flux_onset_detector_core.f
rtl/core/sfod_pkg.sv
rtl/core/sfod_divider.sv
rtl/core/sfod_datapath.sv
rtl/core/sfod_ctrl.sv
rtl/core/spectral_flux_onset_detector_core.sv
bench/tb_spectral_flux_onset_detector_core.sv
